### design/mqtt_publish_deframer_top_defines.svh
// Assertion macros for the MQTT PUBLISH deframer.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef MQTT_PUBLISH_DEFRAMER_TOP_DEFINES_SVH
`define MQTT_PUBLISH_DEFRAMER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MQTTPD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mqttpd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define MQTTPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mqttpd assertion failed");

`endif

### design/mqttpd_pkg.sv
// Types and constants shared by the MQTT PUBLISH deframer.
// No dependencies.
package mqttpd_pkg;

    localparam int MAX_LENGTH_DIGITS_DEF = 4;
    localparam int LEN_W                 = 28;
    localparam int TOPIC_W               = 16;
    localparam logic [3:0] PUBLISH_TYPE  = 4'd3;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_TLEN_HI = 3'd2,
        PH_TLEN_LO = 3'd3,
        PH_TOPIC   = 3'd4,
        PH_PKTID   = 3'd5,
        PH_MESSAGE = 3'd6,
        PH_OTHER   = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        CLS_HEADER    = 3'd0,
        CLS_LENGTH    = 3'd1,
        CLS_TOPIC_LEN = 3'd2,
        CLS_TOPIC     = 3'd3,
        CLS_PKTID     = 3'd4,
        CLS_MESSAGE   = 3'd5,
        CLS_OTHER     = 3'd6
    } byte_class_t;

    typedef struct packed {
        byte_class_t cls;
        logic [3:0]  ptype;
        logic [1:0]  qos;
        logic        last;
        logic        mal;
    } res_t;

endpackage

### design/mqttpd_if.sv
// Valid/ready channel interfaces of the MQTT PUBLISH deframer.
// Standalone; no package needed.
interface mqttpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mqttpd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] byte_class;
    logic [3:0] packet_type;
    logic [1:0] qos_level;
    logic [7:0] out_byte;
    logic       last_of_packet;
    logic       malformed;

    modport source (output valid, output byte_class, output packet_type, output qos_level,
                    output out_byte, output last_of_packet, output malformed, input ready);
    modport sink   (input valid, input byte_class, input packet_type, input qos_level,
                    input out_byte, input last_of_packet, input malformed, output ready);
endinterface

### design/mqttpd_parser.sv
// Per-byte parse state and classification of the MQTT PUBLISH deframer.
// Depends on mqttpd_pkg.
module mqttpd_parser
    import mqttpd_pkg::*;
#(
    parameter int MAX_LENGTH_DIGITS = MAX_LENGTH_DIGITS_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output res_t       res
);

    localparam logic [2:0] MaxDigits = 3'(MAX_LENGTH_DIGITS);

    phase_t             phase_reg, phase_next;
    logic [3:0]         type_reg, type_next;
    logic [1:0]         qos_reg, qos_next;
    logic [LEN_W-1:0]   left_reg, left_next;
    logic [1:0]         digit_reg, digit_next;
    logic [TOPIC_W-1:0] tlen_reg, tlen_next;
    logic [TOPIC_W-1:0] tleft_reg, tleft_next;
    logic [1:0]         id_reg, id_next;
    logic               bad_reg, bad_next;

    logic [LEN_W-1:0]   rem;
    logic [LEN_W-1:0]   len_sum;
    logic [4:0]         shamt;
    logic [TOPIC_W-1:0] tleft_dec;
    logic [1:0]         id_dec;
    logic               payload;

    always_comb
    begin
        phase_next = phase_reg;
        type_next  = type_reg;
        qos_next   = qos_reg;
        left_next  = left_reg;
        digit_next = digit_reg;
        tlen_next  = tlen_reg;
        tleft_next = tleft_reg;
        id_next    = id_reg;
        bad_next   = bad_reg;
        payload    = 1'b0;
        res.cls    = CLS_OTHER;
        res.last   = 1'b0;
        res.mal    = 1'b0;

        rem       = (left_reg != '0) ? left_reg - LEN_W'(1) : '0;
        shamt     = 5'(digit_reg) * 5'd7;
        len_sum   = left_reg + (LEN_W'(rx_byte[6:0]) << shamt);
        tleft_dec = (tleft_reg != '0) ? tleft_reg - TOPIC_W'(1) : '0;
        id_dec    = (id_reg != '0) ? id_reg - 2'd1 : '0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                res.cls    = CLS_HEADER;
                type_next  = rx_byte[7:4];
                qos_next   = rx_byte[2:1];
                left_next  = '0;
                digit_next = '0;
                tlen_next  = '0;
                tleft_next = '0;
                id_next    = '0;
                bad_next   = 1'b0;
                phase_next = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                res.cls   = CLS_LENGTH;
                left_next = len_sum;
                if (rx_byte[7])
                begin
                    if (({1'b0, digit_reg} + 3'd1) >= MaxDigits)
                    begin
                        // runaway length field: end it here and resync
                        bad_next   = 1'b1;
                        res.mal    = 1'b1;
                        res.last   = 1'b1;
                        phase_next = PH_HEADER;
                    end
                    else
                    begin
                        digit_next = digit_reg + 2'd1;
                    end
                end
                else if (len_sum == '0)
                begin
                    res.last   = 1'b1;
                    phase_next = PH_HEADER;
                end
                else
                begin
                    phase_next = (type_reg == PUBLISH_TYPE) ? PH_TLEN_HI : PH_OTHER;
                end
            end
            PH_TLEN_HI:
            begin
                payload    = 1'b1;
                res.cls    = CLS_TOPIC_LEN;
                tlen_next  = {rx_byte, 8'h00};
                if (rem == '0)
                    bad_next = 1'b1;
                phase_next = PH_TLEN_LO;
            end
            PH_TLEN_LO:
            begin
                payload    = 1'b1;
                res.cls    = CLS_TOPIC_LEN;
                tlen_next  = {tlen_reg[15:8], rx_byte};
                tleft_next = {tlen_reg[15:8], rx_byte};
                if (rem < LEN_W'({tlen_reg[15:8], rx_byte}))
                begin
                    bad_next   = 1'b1;
                    phase_next = PH_OTHER;
                end
                else if ({tlen_reg[15:8], rx_byte} == '0)
                begin
                    if (qos_reg != 2'd0)
                    begin
                        if (rem < LEN_W'(2))
                            bad_next = 1'b1;
                        id_next    = 2'd2;
                        phase_next = PH_PKTID;
                    end
                    else
                    begin
                        phase_next = PH_MESSAGE;
                    end
                end
                else
                begin
                    phase_next = PH_TOPIC;
                end
            end
            PH_TOPIC:
            begin
                payload    = 1'b1;
                res.cls    = CLS_TOPIC;
                tleft_next = tleft_dec;
                if (tleft_dec == '0)
                begin
                    if (qos_reg != 2'd0)
                    begin
                        if (rem < LEN_W'(2))
                            bad_next = 1'b1;
                        id_next    = 2'd2;
                        phase_next = PH_PKTID;
                    end
                    else
                    begin
                        phase_next = PH_MESSAGE;
                    end
                end
            end
            PH_PKTID:
            begin
                payload = 1'b1;
                res.cls = CLS_PKTID;
                id_next = id_dec;
                if (id_dec == '0)
                    phase_next = PH_MESSAGE;
            end
            PH_MESSAGE:
            begin
                payload = 1'b1;
                res.cls = CLS_MESSAGE;
            end
            PH_OTHER:
            begin
                payload = 1'b1;
                res.cls = CLS_OTHER;
            end
        endcase

        if (payload)
        begin
            left_next = rem;
            res.mal   = bad_next;
            if (rem == '0)
            begin
                res.last   = 1'b1;
                phase_next = PH_HEADER;
            end
        end

        res.ptype = type_next;
        res.qos   = qos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            type_reg  <= '0;
            qos_reg   <= '0;
            left_reg  <= '0;
            digit_reg <= '0;
            tlen_reg  <= '0;
            tleft_reg <= '0;
            id_reg    <= '0;
            bad_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            qos_reg   <= qos_next;
            left_reg  <= left_next;
            digit_reg <= digit_next;
            tlen_reg  <= tlen_next;
            tleft_reg <= tleft_next;
            id_reg    <= id_next;
            bad_reg   <= bad_next;
        end
    end

endmodule

### design/mqtt_publish_deframer_top.sv
// MQTT PUBLISH deframer, top level: channel registers around the parser.
// Depends on mqttpd_pkg, mqttpd_if.sv, mqttpd_parser and the defines header.
//
// Usage:
//   rx carries the received MQTT stream, one byte per transfer (rx_byte).
//   tx returns one tagged result per byte: byte_class, packet_type,
//   qos_level, the byte itself, last_of_packet and malformed.
//   Each byte lands in an input register; the parser classifies it and
//   updates its packet state while moving it into the output register.
//   Path: a byte taken from rx is held in the input register, then moved
//   into the output register, which drives tx.
//   Throughput: one byte per cycle, sustained while tx.ready stays high,
//   set by the combinational parser step between the two registers.
//   Stall: while tx.ready is low the output register holds its result;
//   one more byte is taken into the input register, then rx.ready drops
//   until tx drains. No byte is dropped or repeated.
//   Reset: both registers empty, parser waits for a fixed-header byte,
//   all counts and the held type/QoS cleared.
//   A runaway length field (too many continuation digits) ends the packet
//   at that digit with malformed set; the next byte is a new header.
`include "mqtt_publish_deframer_top_defines.svh"

module mqtt_publish_deframer_top
    import mqttpd_pkg::*;
#(
    parameter int MAX_LENGTH_DIGITS = MAX_LENGTH_DIGITS_DEF
)(
    input  logic           clk,
    input  logic           rst_n,
    mqttpd_in_if.sink      rx,
    mqttpd_out_if.source   tx
);

    // input stage
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    // output stage
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    res_t       out_res_reg;

    logic       adv;
    logic       take;
    res_t       res;

    // class decodes of the held result, used by the checks
    logic       out_hdr;
    logic       out_pub;

    // parser step moves the held byte into a free or draining output stage
    assign adv  = in_valid_reg && (!out_valid_reg || tx.ready);
    assign take = rx.valid && rx.ready;

    assign rx.ready = !in_valid_reg || adv;

    mqttpd_parser #(
        .MAX_LENGTH_DIGITS(MAX_LENGTH_DIGITS)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (adv),
        .rx_byte (in_byte_reg),
        .res     (res)
    );

    always_comb
    begin
        priority if (take)
            in_valid_next = 1'b1;
        else if (adv)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        priority if (adv)
            out_valid_next = 1'b1;
        else if (tx.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (take)
            in_byte_reg <= rx.rx_byte;
        if (adv)
        begin
            out_byte_reg <= in_byte_reg;
            out_res_reg  <= res;
        end
    end

    assign tx.valid          = out_valid_reg;
    assign tx.byte_class     = out_res_reg.cls;
    assign tx.packet_type    = out_res_reg.ptype;
    assign tx.qos_level      = out_res_reg.qos;
    assign tx.out_byte       = out_byte_reg;
    assign tx.last_of_packet = out_res_reg.last;
    assign tx.malformed      = out_res_reg.mal;

    assign out_hdr = (out_res_reg.cls == CLS_HEADER);
    assign out_pub = (out_res_reg.cls == CLS_TOPIC_LEN) || (out_res_reg.cls == CLS_TOPIC)
                  || (out_res_reg.cls == CLS_PKTID) || (out_res_reg.cls == CLS_MESSAGE);

    // header bytes never carry a fault from the previous packet
    `MQTTPD_ASSERT_NOW(a_hdr_clean, out_valid_reg && out_hdr, !out_res_reg.mal)
    // PUBLISH-only classes appear only under packet type 3
    `MQTTPD_ASSERT_NOW(a_pub_only, out_valid_reg && out_pub, out_res_reg.ptype == PUBLISH_TYPE)
    // a parser step always yields a result next cycle
    `MQTTPD_ASSERT_NEXT(a_adv_fills, adv, out_valid_reg)
    // a taken result with nothing behind it empties the output stage
    `MQTTPD_ASSERT_NEXT(a_drain, out_valid_reg && tx.ready && !adv, !out_valid_reg)

endmodule
